[hdl/lea128_block_cipher_unit_macros.svh]
// assertion macros shared by the lea-128 cipher unit
`ifndef LEA128_BLOCK_CIPHER_UNIT_MACROS_SVH
`define LEA128_BLOCK_CIPHER_UNIT_MACROS_SVH

// implication checked in the same cycle, held off during reset
`define LEA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lea unit: same-cycle check failed");

// implication checked in the next cycle, held off during reset
`define LEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lea unit: next-cycle check failed");

`endif

[hdl/lea_pkg.sv]
// types, constants and rotate helpers of the lea-128 cipher unit
`timescale 1ns / 1ps

package lea_pkg;

	typedef logic [31:0]       word_t;
	typedef logic [3:0][31:0]  blk_t;

	// command codes
	localparam logic CMD_ENC = 1'b0;
	localparam logic CMD_DEC = 1'b1;

	// key schedule delta words, index k at word k
	localparam blk_t KS_DELTA = {32'h78df30ec, 32'h79e27c8a, 32'h44626b02, 32'hc3efe9db};

	// per-word rotation of the key schedule
	localparam int unsigned KS_ROT [4] = '{1, 3, 6, 11};

	function automatic word_t rotl32(word_t v, int unsigned s);
		int unsigned sm;
		sm = s % 32;
		rotl32 = (v << sm) | (v >> ((32 - sm) % 32));
		if (sm == 0) begin
			rotl32 = v;
		end
	endfunction

	function automatic word_t rotr32(word_t v, int unsigned s);
		rotr32 = rotl32(v, (32 - (s % 32)) % 32);
	endfunction

endpackage

[hdl/lea_if.sv]
// handshake channels of the lea-128 cipher unit
`timescale 1ns / 1ps

// block channel: command and one 128-bit block
interface lea_blk_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] block_word0;
	logic [31:0] block_word1;
	logic [31:0] block_word2;
	logic [31:0] block_word3;

	modport source (output valid, command, block_word0, block_word1, block_word2, block_word3,
		input ready);
	modport sink (input valid, command, block_word0, block_word1, block_word2, block_word3,
		output ready);
endinterface

// result channel: one processed 128-bit block
interface lea_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_word0;
	logic [31:0] result_word1;
	logic [31:0] result_word2;
	logic [31:0] result_word3;

	modport source (output valid, result_word0, result_word1, result_word2, result_word3,
		input ready);
	modport sink (input valid, result_word0, result_word1, result_word2, result_word3,
		output ready);
endinterface

// configuration write channel: register index and data word
interface lea_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hdl/lea_key_sched.sv]
// lea-128 key schedule: one round of four key words per cycle
`timescale 1ns / 1ps

module lea_key_sched #(
	parameter int ROUNDS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  lea_pkg::blk_t             key,
	output logic                      busy,
	output logic                      wr_en,
	output logic [$clog2(ROUNDS)-1:0] wr_addr,
	output lea_pkg::blk_t             wr_data
);

	localparam int RW = $clog2(ROUNDS);
	localparam logic [RW-1:0] LAST = RW'(ROUNDS - 1);

	logic          busy_q;
	logic [RW-1:0] idx_q;
	lea_pkg::blk_t t_q;
	lea_pkg::blk_t dr_q;
	lea_pkg::blk_t t_next;
	lea_pkg::word_t d_sel;

	// delta of this round, already turned by the round index
	assign d_sel = dr_q[idx_q[1:0]];

	// four independent add and rotate lanes
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			t_next[j] = lea_pkg::rotl32(t_q[j] + lea_pkg::rotl32(d_sel, j), lea_pkg::KS_ROT[j]);
		end
	end

	// round counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			idx_q <= RW'(idx_q + 1'b1);
			if (idx_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// running key words and turning deltas
	always_ff @(posedge clk) begin
		if (start) begin
			t_q  <= key;
			dr_q <= lea_pkg::KS_DELTA;
		end else if (busy_q) begin
			t_q <= t_next;
			for (int k = 0; k < 4; k++) begin
				dr_q[k] <= lea_pkg::rotl32(dr_q[k], 1);
			end
		end
	end

	assign busy    = busy_q;
	assign wr_en   = busy_q;
	assign wr_addr = idx_q;
	assign wr_data = t_next;

endmodule

[hdl/lea_round.sv]
// one lea round, forward for encryption or inverse for decryption
`timescale 1ns / 1ps

module lea_round (
	input  logic          command,
	input  lea_pkg::blk_t x,
	input  lea_pkg::blk_t rk,
	output lea_pkg::blk_t y
);

	lea_pkg::blk_t enc;
	lea_pkg::blk_t dec;

	// forward arx round
	always_comb begin
		enc[0] = lea_pkg::rotl32((x[0] ^ rk[0]) + (x[1] ^ rk[1]), 9);
		enc[1] = lea_pkg::rotr32((x[1] ^ rk[2]) + (x[2] ^ rk[1]), 5);
		enc[2] = lea_pkg::rotr32((x[2] ^ rk[3]) + (x[3] ^ rk[1]), 3);
		enc[3] = x[0];
	end

	// inverse round, each word leans on the one before
	always_comb begin
		dec[0] = x[3];
		dec[1] = (lea_pkg::rotr32(x[0], 9) - (dec[0] ^ rk[0])) ^ rk[1];
		dec[2] = (lea_pkg::rotl32(x[1], 5) - (dec[1] ^ rk[2])) ^ rk[1];
		dec[3] = (lea_pkg::rotl32(x[2], 3) - (dec[2] ^ rk[3])) ^ rk[1];
	end

	assign y = (command == lea_pkg::CMD_DEC) ? dec : enc;

endmodule

[hdl/lea128_block_cipher_unit.sv]
// lea-128 block cipher unit: key registers, round-key memory, round sequencer
//
// Usage:
//  - cfg writes key words 0..3 (index = word number). Each write restarts the
//    key schedule, which fills the round-key memory at one round per cycle,
//    so a block is taken only once the key schedule has finished.
//  - blk_in takes a command (0 encrypt, 1 decrypt) and a 128-bit block as
//    four words; res_out gives the processed block as four words.
//  - From block accept to result valid: the first round key is fetched at the
//    accept edge, ROUNDS rounds run on the shared round unit, then the output
//    register is loaded. One block is in flight at a time and the sequencer
//    passes through its idle state before taking the next, so no new block is
//    taken before the last one has finished its rounds.
//  - A finished result sits in the output register; the next block may be
//    taken meanwhile. If the receiver stalls, the following block waits
//    after its last round until the output register frees.
//  - Reset clears the key registers and all control state; the round-key
//    memory holds nothing valid until a key word is written.
//  - Key writes are taken only while no block is in work.
`timescale 1ns / 1ps

`include "lea128_block_cipher_unit_macros.svh"

module lea128_block_cipher_unit #(
	parameter int ROUNDS = 24
) (
	input  logic clk,
	input  logic arst_n,
	lea_blk_if.sink   blk_in,
	lea_res_if.source res_out,
	lea_cfg_if.sink   cfg
);

	localparam int RW = $clog2(ROUNDS);
	localparam logic [RW-1:0] LAST = RW'(ROUNDS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]    state_q;
	logic [RW-1:0] rnd_q;
	logic          cmd_q;
	logic          start_q;
	logic          out_valid_q;
	lea_pkg::blk_t key_q;
	lea_pkg::blk_t x_q;
	lea_pkg::blk_t rk_q;
	lea_pkg::blk_t res_q;
	lea_pkg::blk_t y;
	lea_pkg::blk_t blk_word;

	logic          ks_busy;
	logic          ks_wr_en;
	logic [RW-1:0] ks_wr_addr;
	lea_pkg::blk_t ks_wr_data;

	logic          blk_acc;
	logic          cfg_acc;
	logic          out_free;
	logic [RW-1:0] rnd_next;
	logic [RW-1:0] rd_addr;

	// round-key memory
	lea_pkg::blk_t rk_mem [ROUNDS];

	// handshakes
	assign cfg.ready    = (state_q == ST_IDLE);
	assign blk_in.ready = (state_q == ST_IDLE) && !start_q && !ks_busy && !cfg.valid;
	assign blk_acc      = blk_in.valid && blk_in.ready;
	assign cfg_acc      = cfg.valid && cfg.ready;
	assign out_free     = !out_valid_q || res_out.ready;

	assign blk_word = {blk_in.block_word3, blk_in.block_word2,
		blk_in.block_word1, blk_in.block_word0};

	// key schedule generator
	lea_key_sched #(
		.ROUNDS (ROUNDS)
	) u_key_sched (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.key     (key_q),
		.busy    (ks_busy),
		.wr_en   (ks_wr_en),
		.wr_addr (ks_wr_addr),
		.wr_data (ks_wr_data)
	);

	// shared round unit
	lea_round u_round (
		.command (cmd_q),
		.x       (x_q),
		.rk      (rk_q),
		.y       (y)
	);

	// round-key fetch address, one round ahead of the round unit
	assign rnd_next = (rnd_q == LAST) ? rnd_q : RW'(rnd_q + 1'b1);
	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_addr = (blk_in.command == lea_pkg::CMD_DEC) ? LAST : '0;
		end else begin
			rd_addr = (cmd_q == lea_pkg::CMD_DEC) ? RW'(LAST - rnd_next) : rnd_next;
		end
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (ks_wr_en) begin
			rk_mem[ks_wr_addr] <= ks_wr_data;
		end
		rk_q <= rk_mem[rd_addr];
	end

	// sequencer, key registers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rnd_q       <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			key_q       <= '0;
		end else begin
			start_q <= cfg_acc;
			if (cfg_acc) begin
				key_q[cfg.index] <= cfg.data;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res_out.valid && res_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (blk_acc) begin
						state_q <= ST_RUN;
						rnd_q   <= '0;
					end
				end
				ST_RUN: begin
					rnd_q <= rnd_next;
					if (rnd_q == LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// block state, command and result block
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && blk_acc) begin
			x_q   <= blk_word;
			cmd_q <= blk_in.command;
		end else if (state_q == ST_RUN) begin
			x_q <= y;
		end
		if (state_q == ST_DONE && out_free) begin
			res_q <= x_q;
		end
	end

	assign res_out.valid        = out_valid_q;
	assign res_out.result_word0 = res_q[0];
	assign res_out.result_word1 = res_q[1];
	assign res_out.result_word2 = res_q[2];
	assign res_out.result_word3 = res_q[3];

	// checks
	`LEA_ASSERT_NEXT(a_acc_to_run, clk, arst_n, blk_acc, state_q == ST_RUN)
	`LEA_ASSERT_IMPL(a_no_blk_in_sched, clk, arst_n, ks_busy, !blk_in.ready)
	`LEA_ASSERT_NEXT(a_last_round_done, clk, arst_n, state_q == ST_RUN && rnd_q == LAST,
		state_q == ST_DONE)
	`LEA_ASSERT_NEXT(a_done_loads_out, clk, arst_n, state_q == ST_DONE && out_free,
		out_valid_q && state_q == ST_IDLE)

endmodule
